/* design/plen_pkg.sv */
// ----------------------------------------------------------------------------
// plen_pkg
// Shared widths, transaction types and helpers for the polyline length block.
// ----------------------------------------------------------------------------
package plen_pkg;

   localparam int COORD_BITS  = 24;
   localparam int LENGTH_BITS = 48;

   // Sum of two squares of COORD_BITS magnitudes needs one extra bit.
   localparam int SQ_BITS     = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS   = (SQ_BITS + 1) / 2;
   localparam int RAD_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int SQ_CNT_BITS = $clog2(COORD_BITS);
   localparam int RT_CNT_BITS = $clog2(ROOT_BITS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] curve_length;
      logic                   length_saturated;
   } rsp_type;

   // Magnitude of a - b; the difference of two COORD_BITS signed values
   // always fits COORD_BITS unsigned bits.
   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0] d;
      logic [COORD_BITS:0] mag;
      d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      mag = d[COORD_BITS] ? (~d + 1'b1) : d;
      return mag[COORD_BITS-1:0];
   endfunction

endpackage

/* design/plen_sqsum.sv */
// ----------------------------------------------------------------------------
// plen_sqsum
// Bit-serial dx*dx + dy*dy, one multiplier bit of each operand per cycle.
// ----------------------------------------------------------------------------
module plen_sqsum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [plen_pkg::COORD_BITS-1:0]   dx,
   input  logic [plen_pkg::COORD_BITS-1:0]   dy,
   output logic                              done,
   output logic [plen_pkg::SQ_BITS-1:0]      sum
);

   localparam int CB = plen_pkg::COORD_BITS;
   localparam int SB = plen_pkg::SQ_BITS;
   localparam int NB = plen_pkg::SQ_CNT_BITS;

   logic [CB-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [CB-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SB-1:0] acc_ff, acc_in;
   logic [NB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SB-1:0] add_x, add_y;

   // Multipliers are scanned most significant bit first, so the accumulator
   // doubles each cycle and the partial products stay narrow.
   always_comb begin
      mx_in   = mx_ff;
      my_in   = my_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      add_x   = mx_ff[CB-1] ? SB'(dx_ff) : '0;
      add_y   = my_ff[CB-1] ? SB'(dy_ff) : '0;
      if (start) begin
         mx_in   = dx;
         my_in   = dy;
         dx_in   = dx;
         dy_in   = dy;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[SB-2:0], 1'b0} + add_x + add_y;
         mx_in  = {mx_ff[CB-2:0], 1'b0};
         my_in  = {my_ff[CB-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NB'(CB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

/* design/plen_isqrt.sv */
// ----------------------------------------------------------------------------
// plen_isqrt
// Restoring integer square root, one root bit per cycle (floor result).
// ----------------------------------------------------------------------------
module plen_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [plen_pkg::SQ_BITS-1:0]      radicand,
   output logic                              done,
   output logic [plen_pkg::ROOT_BITS-1:0]    root
);

   localparam int RB = plen_pkg::ROOT_BITS;
   localparam int AB = plen_pkg::RAD_BITS;
   localparam int MB = plen_pkg::REM_BITS;
   localparam int NB = plen_pkg::RT_CNT_BITS;

   logic [AB-1:0] rad_ff, rad_in;
   logic [MB-1:0] rem_ff, rem_in;
   logic [RB-1:0] root_ff, root_in;
   logic [NB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [MB-1:0] rem_sh, trial;
   logic          fits;

   // The remainder never exceeds twice the partial root, so its top two bits
   // are zero before each shift and can be dropped.
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[MB-3:0], rad_ff[AB-1:AB-2]};
      trial   = {root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      if (start) begin
         rad_in  = AB'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[AB-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[RB-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == NB'(RB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* design/polyline_length.sv */
// ----------------------------------------------------------------------------
// polyline_length
// Vertices of a planar polyline arrive one transaction at a time as signed
// Q15.8 coordinates. Each segment adds floor(sqrt(dx*dx + dy*dy)) to a running
// Q40.8 length, and the vertex marked last returns the total and the
// saturation flag, after which the block starts a new curve. With closed
// mode set the last vertex also adds the segment back to the first one.
// The first vertex of a curve goes through the post state and back to idle,
// where req_ready is high again. Every other vertex runs from acceptance to
// the next ready through the bit-serial sum of squares, the one-bit-per-cycle
// square root and the control states; a last vertex in closed mode runs the
// pair twice. A last vertex also holds off the next one for as long as the
// previous result still waits to be taken. One vertex is worked on at a time;
// a finished result waits in the output register while the next vertex is
// taken.
// ----------------------------------------------------------------------------
module polyline_length (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plen_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plen_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   localparam int CB = plen_pkg::COORD_BITS;
   localparam int LB = plen_pkg::LENGTH_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_POST = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic signed [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CB-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                 last_ff, last_in;
   logic [LB-1:0]        len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic                 have_ff, have_in;
   logic                 closing_ff, closing_in;
   logic                 closed_ff, closed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   plen_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic signed [CB-1:0]             ax, ay, bx, by;
   logic [CB-1:0]                    dx, dy;
   logic                             sq_start, sq_done;
   logic [plen_pkg::SQ_BITS-1:0]     sq_sum;
   logic                             rt_start, rt_done;
   logic [plen_pkg::ROOT_BITS-1:0]   rt_root;
   logic [LB:0]                      len_sum;

   // The closing pass measures from the last vertex back to the first.
   always_comb begin
      ax = closing_ff ? cur_x_ff   : prev_x_ff;
      ay = closing_ff ? cur_y_ff   : prev_y_ff;
      bx = closing_ff ? first_x_ff : cur_x_ff;
      by = closing_ff ? first_y_ff : cur_y_ff;
      dx = plen_pkg::abs_diff(ax, bx);
      dy = plen_pkg::abs_diff(ay, by);
   end

   assign sq_start = (state_ff == S_DIFF);
   assign rt_start = (state_ff == S_SQ) && sq_done;
   assign len_sum  = {1'b0, len_ff} + (LB + 1)'(rt_root);

   plen_sqsum u_sqsum (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .dx    (dx),
      .dy    (dy),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   plen_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (rt_root)
   );

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      have_in      = have_ff;
      closing_in   = closing_ff;
      closed_in    = csr_write_enable ? csr_write_data : closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_x_in   = req_data.point_x;
               cur_y_in   = req_data.point_y;
               last_in    = req_data.last_point;
               closing_in = 1'b0;
               if (have_ff) begin
                  state_in = S_DIFF;
               end else begin
                  // First vertex of a curve: nothing to measure yet.
                  first_x_in = req_data.point_x;
                  first_y_in = req_data.point_y;
                  have_in    = 1'b1;
                  state_in   = S_POST;
               end
            end
         end
         S_DIFF: begin
            state_in = S_SQ;
         end
         S_SQ: begin
            if (sq_done) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (rt_done) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (len_sum[LB]) begin
               len_in = '1;
               ovf_in = 1'b1;
            end else begin
               len_in = len_sum[LB-1:0];
            end
            if (!closing_ff && last_ff && closed_ff) begin
               closing_in = 1'b1;
               state_in   = S_DIFF;
            end else begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.curve_length     = len_ff;
               rsp_data_in.length_saturated = ovf_ff;
               len_in   = '0;
               ovf_in   = 1'b0;
               have_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         have_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         have_ff      <= have_in;
         closing_ff   <= closing_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/plen_checker.sv */
// ----------------------------------------------------------------------------
// plen_checker
// Port-level checks on the polyline length block, bound to its top level.
// ----------------------------------------------------------------------------
module plen_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input plen_pkg::rsp_type rsp_data
);

   // A stalled result transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // An accepted vertex moves the block out of idle, so req_ready drops after every acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("vertex taken on the cycle after another");

   // A new result is only produced while a vertex is being finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a vertex in progress");

   // Saturation always pins the length at its maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.length_saturated |-> (&rsp_data.curve_length))
      else $error("saturated result below full scale");

endmodule

bind polyline_length plen_checker u_plen_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/polyline_length_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_length_tb
// Self-checking bench for the polyline length block. Curves are queued by an
// initial block, sent by a clocked driver with random gaps and checked by a
// clocked monitor that stalls at random. A predictor follows every accepted
// vertex and queues the length and saturation flag that each last vertex
// should return. Open and closed mode both run, including a mode change while
// a curve is half sent.
// ----------------------------------------------------------------------------
module polyline_length_tb;

   localparam int CB            = plen_pkg::COORD_BITS;
   localparam int LB            = plen_pkg::LENGTH_BITS;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASE_ITEMS   = 190;
   localparam int RANDOM_PHASES = 6;
   localparam logic [LB-1:0] LENGTH_MAX = '1;
   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   plen_pkg::req_type req_data         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   plen_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data   = 1'b0;

   polyline_length dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   plen_pkg::req_type vertex_queue[$];
   plen_pkg::rsp_type length_queue[$];

   // Predictor copy of the curve state and of the mode register.
   logic signed [CB-1:0] first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
   logic [LB-1:0]        length_sum  = '0;
   bit                   curve_open  = 1'b0;
   bit                   sum_clipped = 1'b0;
   bit                   closed_mode = 1'b0;

   // Last vertex that was queued, so that the next one can be a short step.
   logic signed [CB-1:0] gen_x = '0, gen_y = '0;

   int req_gap = 0, rsp_hold = 0, idle_cycles = 0, cycle_count = 0;
   int mismatches = 0, vertices_sent = 0, lengths_checked = 0, closed_lengths = 0;
   int items_queued = 0, pushed_total = 0;
   bit quiet_req = 1'b0, quiet_rsp = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic add_segment(input logic signed [CB-1:0] ax,
                              input logic signed [CB-1:0] ay,
                              input logic signed [CB-1:0] bx,
                              input logic signed [CB-1:0] by);
      longint        diff_x, diff_y;
      logic [63:0]   sq, root, trial;
      logic [LB-1:0] seg;
      int            bit_pos;
      diff_x = longint'(ax) - longint'(bx);
      diff_y = longint'(ay) - longint'(by);
      sq     = diff_x * diff_x + diff_y * diff_y;
      // Floor square root, one result bit at a time from the top.
      root = '0;
      for (bit_pos = 31; bit_pos >= 0; bit_pos--) begin
         trial = root | (64'd1 << bit_pos);
         if (trial * trial <= sq) root = trial;
      end
      seg = root[LB-1:0];
      if (seg > LENGTH_MAX - length_sum) begin
         length_sum  = LENGTH_MAX;
         sum_clipped = 1'b1;
      end else begin
         length_sum = length_sum + seg;
      end
   endtask

   task automatic take_vertex(input plen_pkg::req_type v);
      plen_pkg::rsp_type r;
      if (!curve_open) begin
         first_x    = v.point_x;
         first_y    = v.point_y;
         curve_open = 1'b1;
      end else begin
         add_segment(prev_x, prev_y, v.point_x, v.point_y);
      end
      prev_x = v.point_x;
      prev_y = v.point_y;
      if (v.last_point) begin
         // The mode is taken as it stands when the last vertex arrives.
         if (closed_mode) begin
            add_segment(v.point_x, v.point_y, first_x, first_y);
            closed_lengths++;
         end
         r.curve_length     = length_sum;
         r.length_saturated = sum_clipped;
         length_queue.push_back(r);
         first_x     = '0;
         first_y     = '0;
         prev_x      = '0;
         prev_y      = '0;
         length_sum  = '0;
         sum_clipped = 1'b0;
         curve_open  = 1'b0;
      end
   endtask

   // Driver: a slot is free when nothing is offered or the offer is taken now.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= $urandom_range(0, 17);
      end else begin
         if (req_valid && req_ready) begin
            take_vertex(req_data);
            vertices_sent++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (vertex_queue.size() != 0) begin
               req_data  <= vertex_queue.pop_front();
               req_valid <= 1'b1;
               req_gap   <= quiet_req ? 0 : $urandom_range(0, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: the stall for a result only runs down while that result waits.
   always @(posedge clock) begin : rsp_monitor
      plen_pkg::rsp_type want;
      int                next_hold;
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (length_queue.size() == 0) begin
            $display("%0t: unexpected result: length %0d saturated %0b",
                     $time, rsp_data.curve_length, rsp_data.length_saturated);
            mismatches++;
         end else begin
            want = length_queue.pop_front();
            if (rsp_data.curve_length !== want.curve_length) begin
               $display("%0t: curve_length expected %0d actual %0d",
                        $time, want.curve_length, rsp_data.curve_length);
               mismatches++;
            end
            if (rsp_data.length_saturated !== want.length_saturated) begin
               $display("%0t: length_saturated expected %0b actual %0b",
                        $time, want.length_saturated, rsp_data.length_saturated);
               mismatches++;
            end
            lengths_checked++;
         end
         next_hold = quiet_rsp ? 0 : $urandom_range(0, 17);
         rsp_hold  <= next_hold;
         rsp_ready <= (next_hold == 0);
      end else if (rsp_valid && rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end
   end

   // Watchdog, and now and then a stretch in which either side, or both, never idles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 500 == 0) begin
         quiet_req <= ($urandom_range(0, 3) == 0);
         quiet_rsp <= ($urandom_range(0, 3) == 0);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_vertex(input logic signed [CB-1:0] x,
                              input logic signed [CB-1:0] y,
                              input bit last);
      plen_pkg::req_type v;
      v.point_x    = x;
      v.point_y    = y;
      v.last_point = last;
      vertex_queue.push_back(v);
      gen_x = x;
      gen_y = y;
      items_queued++;
      pushed_total++;
   endtask

   // Wait until every queued vertex is accepted and every result returned,
   // then let the block finish any vertex still in work, since a vertex that
   // is not last returns nothing.
   task automatic settle();
      while (vertex_queue.size() != 0 || req_valid || vertices_sent != pushed_total
             || length_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_closed(input bit value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      closed_mode       = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [CB-1:0] pick_coord(
      input logic signed [CB-1:0] from
   );
      logic signed [CB-1:0] delta;
      case ($urandom_range(0, 9))
         0, 1, 2: pick_coord = CB'($urandom());
         3, 4, 5, 6: begin
            delta      = CB'(int'($urandom_range(0, 2047)) - 1024);
            pick_coord = from + delta;
         end
         7: begin
            case ($urandom_range(0, 3))
               0:       pick_coord = COORD_MAX;
               1:       pick_coord = COORD_MIN;
               2:       pick_coord = '0;
               default: pick_coord = '1;
            endcase
         end
         default: pick_coord = from;
      endcase
   endfunction

   task automatic random_curve();
      int n, i;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (i = 0; i < n; i++) push_vertex(pick_coord(gen_x), pick_coord(gen_y), i == n - 1);
   endtask

   initial begin : stimulus
      int phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Open mode: single vertex, widest segment, a 3-4-5 path, a repeated
      // vertex and a full-range sweep there and back.
      write_closed(1'b0);
      push_vertex(COORD_MAX, COORD_MIN, 1'b1);
      push_vertex(COORD_MIN, COORD_MIN, 1'b0);
      push_vertex(COORD_MAX, COORD_MAX, 1'b1);
      push_vertex(24'sd0, 24'sd0, 1'b0);
      push_vertex(24'sd768, 24'sd0, 1'b0);
      push_vertex(24'sd768, 24'sd1024, 1'b1);
      push_vertex(-24'sd1, -24'sd1, 1'b0);
      push_vertex(-24'sd1, -24'sd1, 1'b0);
      push_vertex(24'sd0, 24'sd0, 1'b1);
      push_vertex(COORD_MAX, 24'sd0, 1'b0);
      push_vertex(COORD_MIN, 24'sd0, 1'b0);
      push_vertex(COORD_MAX, 24'sd0, 1'b1);
      settle();

      // Closed mode: single vertex, two vertices whose segment counts twice,
      // a closed triangle, then a curve left open across the next mode change.
      write_closed(1'b1);
      push_vertex(24'sd5, 24'sd5, 1'b1);
      push_vertex(COORD_MIN, COORD_MAX, 1'b0);
      push_vertex(COORD_MAX, COORD_MIN, 1'b1);
      push_vertex(24'sd0, 24'sd0, 1'b0);
      push_vertex(24'sd768, 24'sd0, 1'b0);
      push_vertex(24'sd768, 24'sd1024, 1'b1);
      push_vertex(24'sd256, -24'sd256, 1'b0);
      push_vertex(24'sd0, 24'sd0, 1'b0);
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_closed(phase[0]);
         items_queued = 0;
         while (items_queued < PHASE_ITEMS) random_curve();
         settle();
      end

      $display("polyline_length_tb: %0d vertices sent, %0d lengths checked (%0d closed)",
               vertices_sent, lengths_checked, closed_lengths);
      $display("polyline_length_tb: both modes run, %0d mismatches", mismatches);
      if (mismatches == 0 && length_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
